@@ src/spq_pkg.sv @@
// Shared constants, the pipeline sideband type and the arctangent table
// for the spectral phase quantizer. No dependencies.
package spq_pkg;

  // Transform geometry.
  localparam int TRANSFORM_SIZE = 64;
  localparam int NYQUIST_BIN    = TRANSFORM_SIZE / 2;
  localparam int BIN_W          = 6;

  // Field widths.
  localparam int IN_W   = 16;
  localparam int OUT_W  = 17;
  localparam int MAG_W  = 17;
  localparam int LVL_W  = 4;

  // Angle handling: CORDIC angles are in units of 2^-32 turn.
  localparam int ANGLE_BITS   = 16;
  localparam int TURN_W       = 32;
  localparam int PHASE_DROP   = TURN_W - ANGLE_BITS;
  localparam int CORDIC_STEPS = 24;
  localparam int ATAN_W       = 30;
  localparam int PRESCALE_SH  = 14;
  localparam int LEVELS_MAX   = 10;
  localparam int SH_W         = 5;

  // Datapath widths.
  localparam int XY_W   = 33;
  localparam int Z_W    = 34;
  localparam int T_W    = 33;
  localparam int APHI_W = Z_W - PHASE_DROP;
  localparam int PROD_W = 51;
  localparam int Q30_SH = 30;

  // Integer square root.
  localparam int RAD_W      = 32;
  localparam int SQ_W       = 31;
  localparam int ROOT_W     = 16;
  localparam int REM_W      = 17;
  localparam int SQRT_STEPS = 16;

  localparam int OUT_LIMIT = 46341;

  localparam logic signed [XY_W-1:0] GAIN_Q30     = XY_W'(652032874);
  localparam logic signed [Z_W-1:0]  VEC_HALF     = Z_W'(33'h0_8000_0000);
  localparam logic signed [T_W-1:0]  ROT_HALF     = T_W'(33'h0_8000_0000);
  localparam logic signed [T_W-1:0]  ROT_QUARTER  = T_W'(33'h0_4000_0000);

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_PHASE_LEVELS = 1'b0;
  localparam logic [LVL_W-1:0]  LEVELS_RESET     = 4'd3;

  // Sideband that travels with each item down the pipeline.
  typedef struct packed {
    logic                    valid;
    logic                    pair;
    logic [BIN_W-1:0]        bin;
    logic signed [IN_W-1:0]  re;
    logic [MAG_W-1:0]        mag;
  } spq_tag_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [ATAN_W-1:0] atan_turn(input logic [SH_W-1:0] i);
    logic [ATAN_W-1:0] a;
    case (i)
      5'd0:    a = 30'd536870912;
      5'd1:    a = 30'd316933406;
      5'd2:    a = 30'd167458907;
      5'd3:    a = 30'd85004756;
      5'd4:    a = 30'd42667331;
      5'd5:    a = 30'd21354465;
      5'd6:    a = 30'd10679838;
      5'd7:    a = 30'd5340245;
      5'd8:    a = 30'd2670163;
      5'd9:    a = 30'd1335087;
      5'd10:   a = 30'd667544;
      5'd11:   a = 30'd333772;
      5'd12:   a = 30'd166886;
      5'd13:   a = 30'd83443;
      5'd14:   a = 30'd41722;
      5'd15:   a = 30'd20861;
      5'd16:   a = 30'd10430;
      5'd17:   a = 30'd5215;
      5'd18:   a = 30'd2608;
      5'd19:   a = 30'd1304;
      5'd20:   a = 30'd652;
      5'd21:   a = 30'd326;
      5'd22:   a = 30'd163;
      5'd23:   a = 30'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ src/spq_polar.sv @@
// Rectangular-to-polar pipeline: vectoring CORDIC for the phase and a
// digit-by-digit integer square root for the magnitude. Uses spq_pkg.
module spq_polar (
  input  logic                                clk,
  input  logic                                rst,
  input  spq_pkg::spq_tag_t                   tag_in,
  input  logic signed [spq_pkg::IN_W-1:0]     re,
  input  logic signed [spq_pkg::IN_W-1:0]     im,
  output spq_pkg::spq_tag_t                   tag_out,
  output logic signed [spq_pkg::Z_W-1:0]      phase
);

  spq_pkg::spq_tag_t                  tag_q [0:spq_pkg::CORDIC_STEPS];
  logic signed [spq_pkg::XY_W-1:0]    vx    [0:spq_pkg::CORDIC_STEPS];
  logic signed [spq_pkg::XY_W-1:0]    vy    [0:spq_pkg::CORDIC_STEPS];
  logic signed [spq_pkg::Z_W-1:0]     vz    [0:spq_pkg::CORDIC_STEPS];

  logic [spq_pkg::SQ_W-1:0]   sq_re_q;
  logic [spq_pkg::SQ_W-1:0]   sq_im_q;
  logic [spq_pkg::RAD_W-1:0]  rad_q  [1:spq_pkg::SQRT_STEPS+1];
  logic [spq_pkg::REM_W-1:0]  rem_q  [1:spq_pkg::SQRT_STEPS+1];
  logic [spq_pkg::ROOT_W-1:0] root_q [1:spq_pkg::SQRT_STEPS+1];
  logic [spq_pkg::MAG_W-1:0]  mag_q  [spq_pkg::SQRT_STEPS+2:spq_pkg::CORDIC_STEPS];

  logic signed [spq_pkg::XY_W-1:0] xs;
  logic signed [spq_pkg::XY_W-1:0] ys;
  logic signed [2*spq_pkg::IN_W-1:0] sq_re_full;
  logic signed [2*spq_pkg::IN_W-1:0] sq_im_full;

  // Scale to the CORDIC working range; a left half-plane vector is mirrored
  // and starts half a turn away.
  assign xs = spq_pkg::XY_W'(re) <<< spq_pkg::PRESCALE_SH;
  assign ys = spq_pkg::XY_W'(im) <<< spq_pkg::PRESCALE_SH;
  assign sq_re_full = re * re;
  assign sq_im_full = im * im;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_q[0] <= '0;
    end else begin
      tag_q[0] <= tag_in;
    end
    if (re[spq_pkg::IN_W-1]) begin
      vx[0] <= -xs;
      vy[0] <= -ys;
      vz[0] <= im[spq_pkg::IN_W-1] ? -spq_pkg::VEC_HALF : spq_pkg::VEC_HALF;
    end else begin
      vx[0] <= xs;
      vy[0] <= ys;
      vz[0] <= '0;
    end
    sq_re_q <= sq_re_full[spq_pkg::SQ_W-1:0];
    sq_im_q <= sq_im_full[spq_pkg::SQ_W-1:0];
  end

  for (genvar j = 1; j <= spq_pkg::CORDIC_STEPS; j++) begin : g_vec
    logic signed [spq_pkg::XY_W-1:0] dx;
    logic signed [spq_pkg::XY_W-1:0] dy;
    logic signed [spq_pkg::Z_W-1:0]  da;

    assign dx = vy[j-1] >>> (j - 1);
    assign dy = vx[j-1] >>> (j - 1);
    assign da = $signed(spq_pkg::Z_W'(spq_pkg::atan_turn(spq_pkg::SH_W'(j - 1))));

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_q[j] <= '0;
      end else begin
        tag_q[j] <= tag_q[j-1];
      end
      if (!vy[j-1][spq_pkg::XY_W-1]) begin
        vx[j] <= vx[j-1] + dx;
        vy[j] <= vy[j-1] - dy;
        vz[j] <= vz[j-1] + da;
      end else begin
        vx[j] <= vx[j-1] - dx;
        vy[j] <= vy[j-1] + dy;
        vz[j] <= vz[j-1] - da;
      end
    end
  end

  // Square root: sum of squares, then one result bit per stage.
  always_ff @(posedge clk) begin
    rad_q[1]  <= spq_pkg::RAD_W'(sq_re_q) + spq_pkg::RAD_W'(sq_im_q);
    rem_q[1]  <= '0;
    root_q[1] <= '0;
  end

  for (genvar j = 2; j <= spq_pkg::SQRT_STEPS + 1; j++) begin : g_sqrt
    localparam int D = spq_pkg::SQRT_STEPS + 1 - j;
    logic [spq_pkg::REM_W+1:0] cur;
    logic [spq_pkg::REM_W+1:0] trial;

    assign cur   = {rem_q[j-1], rad_q[j-1][2*D+1:2*D]};
    assign trial = {1'b0, root_q[j-1], 2'b01};

    always_ff @(posedge clk) begin
      rad_q[j] <= rad_q[j-1];
      if (cur >= trial) begin
        rem_q[j]  <= spq_pkg::REM_W'(cur - trial);
        root_q[j] <= {root_q[j-1][spq_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_q[j]  <= cur[spq_pkg::REM_W-1:0];
        root_q[j] <= {root_q[j-1][spq_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Round to nearest: bump the root when the remainder exceeds it.
  always_ff @(posedge clk) begin
    mag_q[spq_pkg::SQRT_STEPS+2] <=
        spq_pkg::MAG_W'(root_q[spq_pkg::SQRT_STEPS+1]) +
        spq_pkg::MAG_W'(rem_q[spq_pkg::SQRT_STEPS+1] >
                        spq_pkg::REM_W'(root_q[spq_pkg::SQRT_STEPS+1]));
  end

  for (genvar j = spq_pkg::SQRT_STEPS + 3; j <= spq_pkg::CORDIC_STEPS; j++) begin : g_mag
    always_ff @(posedge clk) begin
      mag_q[j] <= mag_q[j-1];
    end
  end

  always_comb begin
    tag_out     = tag_q[spq_pkg::CORDIC_STEPS];
    tag_out.mag = mag_q[spq_pkg::CORDIC_STEPS];
  end

  assign phase = vz[spq_pkg::CORDIC_STEPS];

endmodule

@@ src/spq_rotate.sv @@
// Rotation-mode CORDIC pipeline that turns a quantized angle into Q30
// cosine and sine. Uses spq_pkg.
module spq_rotate (
  input  logic                              clk,
  input  logic                              rst,
  input  spq_pkg::spq_tag_t                 tag_in,
  input  logic [spq_pkg::TURN_W-1:0]        turn,
  output spq_pkg::spq_tag_t                 tag_out,
  output logic signed [spq_pkg::XY_W-1:0]   cos_q30,
  output logic signed [spq_pkg::XY_W-1:0]   sin_q30
);

  spq_pkg::spq_tag_t                tag_q [0:spq_pkg::CORDIC_STEPS+1];
  logic signed [spq_pkg::XY_W-1:0]  rx    [0:spq_pkg::CORDIC_STEPS];
  logic signed [spq_pkg::XY_W-1:0]  ry    [0:spq_pkg::CORDIC_STEPS];
  logic signed [spq_pkg::T_W-1:0]   rt    [0:spq_pkg::CORDIC_STEPS];
  logic                             neg_q [0:spq_pkg::CORDIC_STEPS];

  logic signed [spq_pkg::T_W-1:0] wrapped;
  logic signed [spq_pkg::T_W-1:0] folded;
  logic                           fold_neg;

  // Wrap into (-1/2, 1/2] turn, then fold into [-1/4, 1/4] turn.
  always_comb begin
    if (turn[spq_pkg::TURN_W-1] && (|turn[spq_pkg::TURN_W-2:0])) begin
      wrapped = {1'b1, turn};
    end else begin
      wrapped = {1'b0, turn};
    end
    folded   = wrapped;
    fold_neg = 1'b0;
    if (wrapped > spq_pkg::ROT_QUARTER) begin
      folded   = wrapped - spq_pkg::ROT_HALF;
      fold_neg = 1'b1;
    end else if (wrapped < -spq_pkg::ROT_QUARTER) begin
      folded   = wrapped + spq_pkg::ROT_HALF;
      fold_neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_q[0] <= '0;
    end else begin
      tag_q[0] <= tag_in;
    end
    rx[0]    <= spq_pkg::GAIN_Q30;
    ry[0]    <= '0;
    rt[0]    <= folded;
    neg_q[0] <= fold_neg;
  end

  for (genvar j = 1; j <= spq_pkg::CORDIC_STEPS; j++) begin : g_rot
    logic signed [spq_pkg::XY_W-1:0] dx;
    logic signed [spq_pkg::XY_W-1:0] dy;
    logic signed [spq_pkg::T_W-1:0]  da;

    assign dx = ry[j-1] >>> (j - 1);
    assign dy = rx[j-1] >>> (j - 1);
    assign da = $signed(spq_pkg::T_W'(spq_pkg::atan_turn(spq_pkg::SH_W'(j - 1))));

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_q[j] <= '0;
      end else begin
        tag_q[j] <= tag_q[j-1];
      end
      neg_q[j] <= neg_q[j-1];
      if (!rt[j-1][spq_pkg::T_W-1]) begin
        rx[j] <= rx[j-1] - dx;
        ry[j] <= ry[j-1] + dy;
        rt[j] <= rt[j-1] - da;
      end else begin
        rx[j] <= rx[j-1] + dx;
        ry[j] <= ry[j-1] - dy;
        rt[j] <= rt[j-1] + da;
      end
    end
  end

  // Undo the fold.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_q[spq_pkg::CORDIC_STEPS+1] <= '0;
    end else begin
      tag_q[spq_pkg::CORDIC_STEPS+1] <= tag_q[spq_pkg::CORDIC_STEPS];
    end
    if (neg_q[spq_pkg::CORDIC_STEPS]) begin
      cos_q30 <= -rx[spq_pkg::CORDIC_STEPS];
      sin_q30 <= -ry[spq_pkg::CORDIC_STEPS];
    end else begin
      cos_q30 <= rx[spq_pkg::CORDIC_STEPS];
      sin_q30 <= ry[spq_pkg::CORDIC_STEPS];
    end
  end

  assign tag_out = tag_q[spq_pkg::CORDIC_STEPS+1];

endmodule

@@ src/spectral_phase_quantizer_core.sv @@
// Top level of the spectral phase quantizer: command port, configuration
// register, phase quantizer, output scaling and mirror-bin sequencing.
// Depends on spq_pkg, spq_polar and spq_rotate.
//
//  Channel   Handshake                        Payload
//  -------   -------------------------------  -----------------------------------
//  input     start high while busy low        bin_index, real_part, imag_part
//  result    out_valid strobe, one cycle      out_bin, out_real, out_imag,
//                                             last_of_bin
//  config    psel/penable/pwrite, pready = 1  paddr, pwdata, prdata
//
// Every bin runs down one fixed-latency pipeline: 25 stages of vectoring CORDIC
// (with the square root alongside), two quantizer stages, 26 stages of rotation
// CORDIC, a multiply stage, a round/saturate stage and the output register.
// The first result beat leaves the output register at the end of that chain;
// the mirror beat of bins 1 to 31 follows in the next cycle. Because the result
// port carries one beat per cycle, busy is registered high on accepting a bin 1 to
// 31 and holds off the slot right behind it, so such bins cannot enter back to back;
// DC, Nyquist and out-of-range bins (no result) can enter in every cycle busy is low.
// rst is synchronous and clears every valid bit in the pipeline, busy, the
// pending mirror beat and sets phase_levels_log2 to 3. The receiver cannot
// stall, so the pipeline never holds; every beat is shown for exactly one cycle.
module spectral_phase_quantizer_core (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                start,
  output logic                                busy,
  input  logic [spq_pkg::BIN_W-1:0]           bin_index,
  input  logic signed [spq_pkg::IN_W-1:0]     real_part,
  input  logic signed [spq_pkg::IN_W-1:0]     imag_part,

  output logic                                out_valid,
  output logic [spq_pkg::BIN_W-1:0]           out_bin,
  output logic signed [spq_pkg::OUT_W-1:0]    out_real,
  output logic signed [spq_pkg::OUT_W-1:0]    out_imag,
  output logic                                last_of_bin,

  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [spq_pkg::ADDR_W-1:0]          paddr,
  input  logic [spq_pkg::DATA_W-1:0]          pwdata,
  output logic [spq_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  logic                       accept;
  logic                       is_pass;
  logic                       is_pair;
  spq_pkg::spq_tag_t          in_tag;
  logic [spq_pkg::LVL_W-1:0]  phase_levels_log2;

  spq_pkg::spq_tag_t                polar_tag;
  logic signed [spq_pkg::Z_W-1:0]   polar_phase;

  // Quantizer stages.
  logic [spq_pkg::Z_W-1:0]          phase_abs;
  logic [spq_pkg::Z_W-1:0]          phase_rnd;
  spq_pkg::spq_tag_t                q1_tag;
  logic [spq_pkg::APHI_W-1:0]       q1_aphi;
  logic                             q1_neg;
  logic [spq_pkg::LVL_W-1:0]        levels;
  logic [spq_pkg::APHI_W-1:0]       lvl_half;
  logic [spq_pkg::APHI_W-1:0]       lvl_mask;
  logic [spq_pkg::APHI_W-1:0]       lvl_rounded;
  logic [spq_pkg::TURN_W-1:0]       turn_mag;
  spq_pkg::spq_tag_t                q2_tag;
  logic [spq_pkg::TURN_W-1:0]       q2_turn;

  spq_pkg::spq_tag_t                rot_tag;
  logic signed [spq_pkg::XY_W-1:0]  rot_cos;
  logic signed [spq_pkg::XY_W-1:0]  rot_sin;

  spq_pkg::spq_tag_t                m_tag;
  logic signed [spq_pkg::PROD_W-1:0] m_real;
  logic signed [spq_pkg::PROD_W-1:0] m_imag;

  spq_pkg::spq_tag_t                r_tag;
  logic signed [spq_pkg::OUT_W-1:0] r_real;
  logic signed [spq_pkg::OUT_W-1:0] r_imag;

  logic                             mirror_pending;

  // Scale a Q30 product back to raw units, rounding half away from zero and
  // clipping to the output range.
  function automatic logic signed [spq_pkg::OUT_W-1:0] scale_round(
      input logic signed [spq_pkg::PROD_W-1:0] p);
    logic [spq_pkg::PROD_W-1:0]        a;
    logic [spq_pkg::PROD_W-1:0]        r;
    logic signed [spq_pkg::OUT_W-1:0]  m;
    a = p[spq_pkg::PROD_W-1] ? spq_pkg::PROD_W'(-p) : spq_pkg::PROD_W'(p);
    r = (a + (spq_pkg::PROD_W'(1) << (spq_pkg::Q30_SH - 1))) >> spq_pkg::Q30_SH;
    if (r > spq_pkg::PROD_W'(spq_pkg::OUT_LIMIT)) begin
      r = spq_pkg::PROD_W'(spq_pkg::OUT_LIMIT);
    end
    m = r[spq_pkg::OUT_W-1:0];
    return p[spq_pkg::PROD_W-1] ? -m : m;
  endfunction

  // ---------------------------------------------------------------------------
  // Command port. DC and Nyquist pass the real part through as one beat with a zero
  // imaginary part; bins 1 to 31 give the bin and its mirror; anything above Nyquist is taken and dropped.
  // ---------------------------------------------------------------------------
  assign accept  = start && !busy;
  assign is_pass = (bin_index == '0) ||
                   (bin_index == spq_pkg::BIN_W'(spq_pkg::NYQUIST_BIN));
  assign is_pair = (bin_index != '0) &&
                   (bin_index < spq_pkg::BIN_W'(spq_pkg::NYQUIST_BIN));

  always_comb begin
    in_tag       = '0;
    in_tag.valid = accept && (is_pass || is_pair);
    in_tag.pair  = is_pair;
    in_tag.bin   = bin_index;
    in_tag.re    = real_part;
  end

  // A two-beat bin occupies the result port for both of its beats, so the slot right
  // behind it is held off.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= accept && is_pair;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration register. Only the level count is implemented; writes to
  // other addresses are dropped and read back as zero.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_levels_log2 <= spq_pkg::LEVELS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[spq_pkg::ADDR_W-1:2] == spq_pkg::REG_PHASE_LEVELS)) begin
      phase_levels_log2 <= pwdata[spq_pkg::LVL_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[spq_pkg::ADDR_W-1:2])
      spq_pkg::REG_PHASE_LEVELS: prdata = spq_pkg::DATA_W'(phase_levels_log2);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Magnitude and phase.
  // ---------------------------------------------------------------------------
  spq_polar u_polar (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (in_tag),
    .re      (real_part),
    .im      (imag_part),
    .tag_out (polar_tag),
    .phase   (polar_phase)
  );

  // ---------------------------------------------------------------------------
  // Phase quantizer. First stage rounds the 2^-32 turn phase to ANGLE_BITS,
  // second stage rounds that to the configured level count and rebuilds the
  // angle as a 32-bit turn. Both roundings work on the magnitude and put the
  // sign back afterwards, which gives half-away-from-zero behavior.
  // ---------------------------------------------------------------------------
  assign phase_abs = polar_phase[spq_pkg::Z_W-1] ? spq_pkg::Z_W'(-polar_phase)
                                                 : spq_pkg::Z_W'(polar_phase);
  assign phase_rnd = phase_abs + (spq_pkg::Z_W'(1) << (spq_pkg::PHASE_DROP - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_tag <= '0;
    end else begin
      q1_tag <= polar_tag;
    end
    q1_aphi <= spq_pkg::APHI_W'(phase_rnd >> spq_pkg::PHASE_DROP);
    q1_neg  <= polar_phase[spq_pkg::Z_W-1];
  end

  always_comb begin
    if (phase_levels_log2 > spq_pkg::LVL_W'(spq_pkg::LEVELS_MAX)) begin
      levels = spq_pkg::LVL_W'(spq_pkg::LEVELS_MAX);
    end else begin
      levels = phase_levels_log2;
    end
    lvl_half = spq_pkg::APHI_W'(1) <<
               (spq_pkg::SH_W'(spq_pkg::ANGLE_BITS - 1) - spq_pkg::SH_W'(levels));
    lvl_mask = (spq_pkg::APHI_W'(1) <<
               (spq_pkg::SH_W'(spq_pkg::ANGLE_BITS) - spq_pkg::SH_W'(levels))) -
               spq_pkg::APHI_W'(1);
    lvl_rounded = (q1_aphi + lvl_half) & ~lvl_mask;
    // Only the low ANGLE_BITS survive the move to a 32-bit turn; the rest is
    // whole turns.
    turn_mag = {lvl_rounded[spq_pkg::ANGLE_BITS-1:0], {spq_pkg::PHASE_DROP{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q2_tag <= '0;
    end else begin
      q2_tag <= q1_tag;
    end
    q2_turn <= q1_neg ? -turn_mag : turn_mag;
  end

  // ---------------------------------------------------------------------------
  // Cosine and sine of the quantized angle.
  // ---------------------------------------------------------------------------
  spq_rotate u_rotate (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (q2_tag),
    .turn    (q2_turn),
    .tag_out (rot_tag),
    .cos_q30 (rot_cos),
    .sin_q30 (rot_sin)
  );

  // ---------------------------------------------------------------------------
  // Rebuild the bin: magnitude times cosine and sine, then round and clip.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tag <= '0;
    end else begin
      m_tag <= rot_tag;
    end
    m_real <= $signed({1'b0, rot_tag.mag}) * rot_cos;
    m_imag <= $signed({1'b0, rot_tag.mag}) * rot_sin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_tag <= '0;
    end else begin
      r_tag <= m_tag;
    end
    r_real <= scale_round(m_real);
    r_imag <= scale_round(m_imag);
  end

  // ---------------------------------------------------------------------------
  // Result port. A bin 1 to 31 shows bin k first, then its mirror 64-k with
  // the imaginary part negated. The real part is simply held for the mirror.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      mirror_pending <= 1'b0;
    end else if (r_tag.valid) begin
      out_valid      <= 1'b1;
      mirror_pending <= r_tag.pair;
    end else if (mirror_pending) begin
      out_valid      <= 1'b1;
      mirror_pending <= 1'b0;
    end else begin
      out_valid      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (r_tag.valid) begin
      out_bin <= r_tag.bin;
      if (r_tag.pair) begin
        out_real    <= r_real;
        out_imag    <= r_imag;
        last_of_bin <= 1'b0;
      end else begin
        out_real    <= {r_tag.re[spq_pkg::IN_W-1], r_tag.re};
        out_imag    <= '0;
        last_of_bin <= 1'b1;
      end
    end else if (mirror_pending) begin
      out_bin     <= spq_pkg::BIN_W'(spq_pkg::TRANSFORM_SIZE - int'(out_bin));
      out_imag    <= -out_imag;
      last_of_bin <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  // The hold-off after a two-beat bin must keep the next bin out of the
  // mirror slot.
  a_no_slot_clash: assert property (@(posedge clk) disable iff (rst)
      !(r_tag.valid && mirror_pending))
    else $error("bin reached the result stage while a mirror beat was pending");

  // A first beat of a pair is always followed by its closing mirror beat.
  a_mirror_follows: assert property (@(posedge clk) disable iff (rst)
      (out_valid && !last_of_bin) |=> (out_valid && last_of_bin))
    else $error("mirror beat missing after first beat of a bin");

  // busy is only ever raised by a bin that produces two beats.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
      busy |-> ($past(start) && !$past(busy) && ($past(bin_index) != '0) &&
                ($past(bin_index) < spq_pkg::BIN_W'(spq_pkg::NYQUIST_BIN))))
    else $error("busy raised without a two-beat bin being accepted");

  // Rebuilt values never leave the clipped range.
  a_out_range: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> ((out_real <= spq_pkg::OUT_LIMIT) && (out_real >= -spq_pkg::OUT_LIMIT) &&
                     (out_imag <= spq_pkg::OUT_LIMIT) && (out_imag >= -spq_pkg::OUT_LIMIT)))
    else $error("result value outside the output range");

endmodule
